FILE: sv/sbp_pkg.sv
// Shared types and constants for the symbol-to-byte packer.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package sbp_pkg;

  // Symbol width register: reset value and usable range.
  localparam logic [4:0] SymbolBitsReset = 5'd11;
  localparam logic [4:0] SymbolBitsMin   = 5'd9;
  localparam logic [4:0] SymbolBitsMax   = 5'd24;

  // One input item.
  typedef struct packed {
    logic [23:0] symbol_value;
    logic        last_symbol;
  } sym_in_t;

  // One result item.
  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_byte;
  } byte_out_t;

  // One classified item handed from the front end to the back end.
  // Bytes are left-aligned: byte k sits in bits [31-8k -: 8].
  typedef struct packed {
    logic [31:0] aligned;
    logic [1:0]  last_idx;
    logic        last;
  } job_t;

endpackage

`default_nettype wire

FILE: sv/symbol_to_byte_packer.sv
// Top level of the symbol-to-byte packer: front end, job queue, back end.
// Depends on sbp_pkg, sbp_front, sbp_queue and sbp_back.
//
//   Channel | Direction | Handshake               | Payload
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (sbp_pkg::sym_in_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (sbp_pkg::byte_out_t)
//   cfg     | input     | cfg_we_i (no wait)      | cfg_wdata_i (symbol width)
//
// Each item becomes one to four bytes (up to three for a 24-bit symbol, four with a
// padded flush byte); the back end sends one byte a cycle unless the output stalls.
// The front end takes an item every cycle while the two-entry job queue has room.
// Reset clears the leftover bits, the queue and the output valid flag and sets the
// width to 11. A stall at the output fills the queue, then drops in_ready_o.
`default_nettype none

module symbol_to_byte_packer (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [4:0]         cfg_wdata_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  sbp_pkg::sym_in_t   in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output sbp_pkg::byte_out_t out_data_o
);

  sbp_pkg::job_t push_job, head_job;
  logic          push, pop, q_empty, q_full;

  // Front end: width register, leftover bits, job building.
  sbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  // Job queue.
  sbp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .data_o  (head_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Back end: byte emission.
  sbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: sv/sbp_front.sv
// Front end of the packer: holds the width register and the leftover bits,
// and turns each accepted symbol into a left-aligned job. Uses sbp_pkg.
`default_nettype none

module sbp_front (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             cfg_we_i,
  input  wire  [4:0]      cfg_wdata_i,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  sbp_pkg::sym_in_t in_data_i,
  input  wire             q_full_i,
  output logic            push_o,
  output sbp_pkg::job_t   job_o
);

  logic [4:0]  symbol_bits_q;
  logic [6:0]  pend_bits_q, pend_bits_d;
  logic [2:0]  pend_cnt_q, pend_cnt_d;
  logic [4:0]  width;
  logic [23:0] sym_m;
  logic [4:0]  total;
  logic [2:0]  rem;
  logic [1:0]  full;
  logic        extra;
  logic [5:0]  sh_p, sh_s;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Clamp the configured width to the supported range.
  always_comb begin
    if (symbol_bits_q < sbp_pkg::SymbolBitsMin) begin
      width = sbp_pkg::SymbolBitsMin;
    end else if (symbol_bits_q > sbp_pkg::SymbolBitsMax) begin
      width = sbp_pkg::SymbolBitsMax;
    end else begin
      width = symbol_bits_q;
    end
  end

  // Append the masked symbol after the leftover bits and left-align the result.
  always_comb begin
    sym_m = in_data_i.symbol_value & ~(24'hFF_FFFF << width);
    total = {2'b00, pend_cnt_q} + width;
    rem   = total[2:0];
    full  = total[4:3];
    extra = in_data_i.last_symbol && (rem != 3'd0);
    sh_p  = 6'd32 - {3'b000, pend_cnt_q};
    sh_s  = 6'd32 - {1'b0, total};
    job_o.aligned  = ({25'd0, pend_bits_q} << sh_p) | ({8'd0, sym_m} << sh_s);
    job_o.last_idx = full - 2'd1 + {1'b0, extra};
    job_o.last     = in_data_i.last_symbol;
  end

  // Leftover bits after this item; a last item clears them.
  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    if (push_o) begin
      if (in_data_i.last_symbol) begin
        pend_bits_d = 7'd0;
        pend_cnt_d  = 3'd0;
      end else begin
        pend_bits_d = sym_m[6:0] & ~(7'h7F << rem);
        pend_cnt_d  = rem;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symbol_bits_q <= sbp_pkg::SymbolBitsReset;
      pend_bits_q   <= 7'd0;
      pend_cnt_q    <= 3'd0;
    end else begin
      if (cfg_we_i) begin
        symbol_bits_q <= cfg_wdata_i;
      end
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sbp_queue.sv
// Two-entry job queue between the front and back ends of the packer.
// Uses sbp_pkg for the job type.
`default_nettype none

module sbp_queue (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           push_i,
  input  sbp_pkg::job_t data_i,
  input  wire           pop_i,
  output sbp_pkg::job_t data_o,
  output logic          empty_o,
  output logic          full_o
);

  sbp_pkg::job_t slot_q [2];
  sbp_pkg::job_t slot_d [2];
  logic [1:0]    cnt_q, cnt_d;
  logic          widx;

  assign data_o  = slot_q[0];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

  // Pop shifts the second slot forward; push lands behind what remains.
  always_comb begin
    slot_d = slot_q;
    widx   = 1'b0;
    if (pop_i) begin
      slot_d[0] = slot_q[1];
    end
    if (push_i) begin
      widx = cnt_q[0] ^ pop_i;
      slot_d[widx] = data_i;
    end
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

`default_nettype wire

FILE: sv/sbp_back.sv
// Back end of the packer: walks the bytes of the head job, one per cycle while the
// output is not stalled, into the output register. Uses sbp_pkg.
`default_nettype none

module sbp_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  sbp_pkg::job_t     job_i,
  input  wire               empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output sbp_pkg::byte_out_t out_data_o
);

  logic [1:0]          bidx_q, bidx_d;
  logic                out_valid_q, out_valid_d;
  sbp_pkg::byte_out_t  out_q, out_d;
  logic                load;
  logic                final_byte;
  logic [7:0]          sel;

  assign load       = !empty_i && (!out_valid_q || out_ready_i);
  assign final_byte = (bidx_q == job_i.last_idx);
  assign pop_o      = load && final_byte;

  // Byte selection from the left-aligned job.
  always_comb begin
    case (bidx_q)
      2'd0:    sel = job_i.aligned[31:24];
      2'd1:    sel = job_i.aligned[23:16];
      2'd2:    sel = job_i.aligned[15:8];
      default: sel = job_i.aligned[7:0];
    endcase
  end

  // Output register and byte counter.
  always_comb begin
    bidx_d      = bidx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      bidx_d          = final_byte ? 2'd0 : bidx_q + 2'd1;
      out_d.byte_out  = sel;
      out_d.last_byte = job_i.last && final_byte;
      out_valid_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bidx_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      bidx_q      <= bidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: sv/sbp_checker.sv
// Port-level checker for the symbol-to-byte packer, bound to the top level.
// Depends on sbp_pkg and symbol_to_byte_packer.
`default_nettype none

module sbp_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_ready_o,
  input wire                out_valid_o,
  input wire                out_ready_i,
  input sbp_pkg::byte_out_t out_data_o
);

  // A stalled result item keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid_o dropped while stalled");

  // A stalled result item keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("out_data_o changed while stalled");

  // The input only backs up when a result is waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input blocked with no result pending");

  // An accepted item shows a result once it has passed the job queue and the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("accepted item produced no result");

endmodule

bind symbol_to_byte_packer sbp_checker u_sbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
